// ----- rtl/gsoc_pkg.sv -----
// Package for the grid segment obstacle checker: commands, config indexes,
// default sizes and small arithmetic helpers. No dependencies.
`default_nettype none
package gsoc_pkg;
    localparam int GRID_W_DEF = 16;
    localparam int GRID_H_DEF = 16;

    localparam logic [1:0] MODE_SET_BLOCKED = 2'd0;
    localparam logic [1:0] MODE_SET_FREE    = 2'd1;
    localparam logic [1:0] MODE_PATH        = 2'd2;
    localparam logic [1:0] MODE_CELL        = 2'd3;

    localparam logic [1:0] CFG_GATE_LX = 2'd0;
    localparam logic [1:0] CFG_GATE_LY = 2'd1;
    localparam logic [1:0] CFG_GATE_RX = 2'd2;
    localparam logic [1:0] CFG_GATE_RY = 2'd3;

    localparam logic [5:0] GATE_LX_RST = 6'd14;
    localparam logic [5:0] GATE_LY_RST = 6'd15;
    localparam logic [5:0] GATE_RX_RST = 6'd15;
    localparam logic [5:0] GATE_RY_RST = 6'd14;

    // scaled coordinates stay within about +-650, products within 2^22
    localparam int CW = 12;
    localparam int PW = 26;

    typedef logic signed [CW-1:0] crd_t;
    typedef logic signed [PW-1:0] prod_t;

    function automatic logic signed [1:0] sgn(input prod_t v);
        sgn = (v == '0) ? 2'sd0 : (v[PW-1] ? -2'sd1 : 2'sd1);
    endfunction

    // closed overlap of spans [a,b] and [c,d], endpoints in any order
    function automatic logic span_ov(input crd_t a, input crd_t b,
                                     input crd_t c, input crd_t d);
        crd_t lo1, hi1, lo2, hi2, lo, hi;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        lo2 = (c < d) ? c : d;
        hi2 = (c < d) ? d : c;
        lo  = (lo1 > lo2) ? lo1 : lo2;
        hi  = (hi1 < hi2) ? hi1 : hi2;
        span_ov = (lo <= hi);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/grid_segment_obstacle_check.sv -----
// Grid segment obstacle checker. A path query scans each cell of its box (up
// to 128 x 128 cells) and tests the edges of each blocked cell, ending early on
// the first edge hit, else tests the gate, on one shared cross product unit
// stepping through the sign tests. One item at a time; the next is taken no
// earlier than the cycle after the result is taken. Reset (synchronous,
// aresetn low) clears the bitmap with a sweep over 2^(XB+YB) entries
// (GRID_W*GRID_H for power-of-two sizes); gates take defaults.
`default_nettype none
module grid_segment_obstacle_check
    import gsoc_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [5:0]        cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    input  wire logic signed [6:0] s_x_from,
    input  wire logic signed [6:0] s_y_from,
    input  wire logic signed [6:0] s_x_to,
    input  wire logic signed [6:0] s_y_to,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_answer,
    output logic                   m_out_of_grid
);
    localparam int XB = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YB = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int AB = XB + YB;
    localparam int NC = 1 << AB;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_CELL  = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SCHK  = 4'd5;
    localparam logic [3:0] ST_EDGE  = 4'd6;
    localparam logic [3:0] ST_GATE  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       mem [NC];
    logic       rd_reg;
    logic [AB-1:0] clr_reg;

    logic [5:0] glx_reg, gly_reg, grx_reg, gry_reg;
    logic [1:0] mode_reg;
    logic signed [6:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [6:0] ci_reg, cj_reg;
    logic [2:0] step_reg;   // edge index or gate product index
    logic [1:0] sub_reg;    // cross product within an edge test
    logic       ans_reg, oog_reg;
    logic signed [1:0] s1_reg, s2_reg, s3_reg;
    logic       ov_reg;

    function automatic logic in_grid(input logic signed [6:0] x,
                                     input logic signed [6:0] y);
        in_grid = !x[6] && !y[6] && (32'(x) < GRID_W) && (32'(y) < GRID_H);
    endfunction

    function automatic logic [AB-1:0] addr(input logic signed [6:0] x,
                                           input logic signed [6:0] y);
        logic [6:0] xu, yu;
        xu = x;
        yu = y;
        addr = {yu[YB-1:0], xu[XB-1:0]};
    endfunction

    logic signed [6:0] minx, maxx, miny, maxy;
    assign minx = (x0_reg < x1_reg) ? x0_reg : x1_reg;
    assign maxx = (x0_reg < x1_reg) ? x1_reg : x0_reg;
    assign miny = (y0_reg < y1_reg) ? y0_reg : y1_reg;
    assign maxy = (y0_reg < y1_reg) ? y1_reg : y0_reg;

    // segment endpoints, scaled
    crd_t ax, ay, bx, by;
    assign ax = crd_t'(x0_reg) * crd_t'(10) + crd_t'(5);
    assign ay = crd_t'(y0_reg) * crd_t'(10) + crd_t'(5);
    assign bx = crd_t'(x1_reg) * crd_t'(10) + crd_t'(5);
    assign by = crd_t'(y1_reg) * crd_t'(10) + crd_t'(5);

    crd_t cl, cr, ct, cb;
    assign cl = crd_t'(ci_reg) * crd_t'(10);
    assign cr = cl + crd_t'(10);
    assign ct = crd_t'(cj_reg) * crd_t'(10);
    assign cb = ct + crd_t'(10);

    // current edge q1->q2, or the gate segment
    crd_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    crd_t glx, gly, grx, gry;
    assign glx = crd_t'({1'b0, glx_reg});
    assign gly = crd_t'({1'b0, gly_reg});
    assign grx = crd_t'({1'b0, grx_reg});
    assign gry = crd_t'({1'b0, gry_reg});

    always_comb begin
        p1x = ax; p1y = ay; p2x = bx; p2y = by;
        q1x = cl; q1y = ct; q2x = cr; q2y = ct;
        if (state_reg == ST_GATE) begin
            p1x = crd_t'(x0_reg); p1y = crd_t'(y0_reg);
            p2x = crd_t'(x1_reg); p2y = crd_t'(y1_reg);
            q1x = glx; q1y = gly; q2x = grx; q2y = gry;
        end else begin
            case (step_reg[1:0])
                2'd0: begin q1x = cl; q1y = ct; q2x = cr; q2y = ct; end
                2'd1: begin q1x = cr; q1y = ct; q2x = cr; q2y = cb; end
                2'd2: begin q1x = cr; q1y = cb; q2x = cl; q2y = cb; end
                default: begin q1x = cl; q1y = cb; q2x = cl; q2y = ct; end
            endcase
        end
    end

    // shared cross product unit: (b-a) x (c-a)
    crd_t ka, kb, kc, kd, ke, kf;
    always_comb begin
        ka = p1x; kb = p1y; kc = p2x; kd = p2y; ke = q1x; kf = q1y;
        if (state_reg == ST_GATE) begin
            unique case (step_reg)
                3'd0: begin ka = p1x; kb = p1y; kc = p2x; kd = p2y; ke = q1x; kf = q1y; end
                3'd1: begin ka = p1x; kb = p1y; kc = p2x; kd = p2y; ke = q2x; kf = q2y; end
                3'd2: begin ka = q1x; kb = q1y; kc = q2x; kd = q2y; ke = p1x; kf = p1y; end
                3'd3: begin ka = q1x; kb = q1y; kc = q2x; kd = q2y; ke = p2x; kf = p2y; end
                3'd4: begin ka = glx; kb = gly; kc = grx - glx; kd = gry - gly;
                            ke = grx; kf = gry; end
                3'd5: begin ka = glx; kb = gly; kc = p2x; kd = p2y; ke = grx; kf = gry; end
                default: begin ka = glx; kb = gly; kc = p1x; kd = p1y;
                               ke = grx; kf = gry; end
            endcase
        end else begin
            unique case (sub_reg)
                2'd0: begin ka = p1x; kb = p1y; kc = p2x; kd = p2y; ke = q1x; kf = q1y; end
                2'd1: begin ka = p1x; kb = p1y; kc = p2x; kd = p2y; ke = q2x; kf = q2y; end
                2'd2: begin ka = q1x; kb = q1y; kc = q2x; kd = q2y; ke = p1x; kf = p1y; end
                default: begin ka = q1x; kb = q1y; kc = q2x; kd = q2y;
                               ke = p2x; kf = p2y; end
            endcase
        end
    end

    prod_t cx_val;
    logic signed [1:0] cs;
    assign cx_val = prod_t'(kc - ka) * prod_t'(kf - kb) - prod_t'(kd - kb) * prod_t'(ke - ka);
    assign cs = sgn(cx_val);

    logic ov_now;
    assign ov_now = span_ov(p1x, p2x, q1x, q2x) && span_ov(p1y, p2y, q1y, q2y);

    logic signed [3:0] m12, m34;
    assign m12 = 4'(s1_reg) * 4'(s2_reg);
    assign m34 = 4'(s3_reg) * 4'(cs);

    logic edge_hit;
    assign edge_hit = ov_reg && (m12 <= 0) && (m34 <= 0);

    logic acc;
    assign acc = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    logic last_i, last_j;
    assign last_i = (ci_reg == maxx);
    assign last_j = (cj_reg == maxy);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLR)
            mem[clr_reg] <= 1'b0;
        else if (state_reg == ST_RD && mode_reg[1] == 1'b0 && in_grid(x0_reg, y0_reg))
            mem[addr(x0_reg, y0_reg)] <= (mode_reg == MODE_SET_BLOCKED);
        if (state_reg == ST_SRD)
            rd_reg <= mem[addr(ci_reg, cj_reg)];
        else
            rd_reg <= mem[addr(x0_reg, y0_reg)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glx_reg <= GATE_LX_RST;
            gly_reg <= GATE_LY_RST;
            grx_reg <= GATE_RX_RST;
            gry_reg <= GATE_RY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GATE_LX: glx_reg <= cfg_data;
                CFG_GATE_LY: gly_reg <= cfg_data;
                CFG_GATE_RX: grx_reg <= cfg_data;
                default:     gry_reg <= cfg_data;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:  if (32'(clr_reg) == NC - 1) state_next = ST_IDLE;
            ST_IDLE: if (acc) state_next = ST_RD;
            ST_RD:   state_next = (mode_reg == MODE_PATH) ? ST_SRD : ST_CELL;
            ST_CELL: state_next = ST_OUT;
            ST_SRD:  state_next = ST_SCHK;
            ST_SCHK: begin
                if (!(in_grid(ci_reg, cj_reg) && rd_reg))
                    state_next = (last_j && last_i) ? ST_GATE : ST_SRD;
                else
                    state_next = ST_EDGE;
            end
            ST_EDGE: begin
                if (sub_reg == 2'd3) begin
                    if (edge_hit)
                        state_next = ST_OUT;
                    else if (step_reg == 3'd3)
                        state_next = (last_j && last_i) ? ST_GATE : ST_SRD;
                end
            end
            ST_GATE: if (step_reg == 3'd6) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: if (acc) begin
                    mode_reg <= s_mode;
                    x0_reg <= s_x_from; y0_reg <= s_y_from;
                    x1_reg <= s_x_to;   y1_reg <= s_y_to;
                end
                ST_RD: begin
                    ans_reg <= 1'b0;
                    oog_reg <= !in_grid(x0_reg, y0_reg) ||
                               (mode_reg == MODE_PATH && !in_grid(x1_reg, y1_reg));
                    ci_reg <= minx;
                    cj_reg <= miny;
                end
                ST_CELL: begin
                    if (mode_reg == MODE_CELL)
                        ans_reg <= in_grid(x0_reg, y0_reg) && !rd_reg;
                    m_valid <= 1'b1;
                end
                ST_SCHK: begin
                    step_reg <= '0;
                    sub_reg  <= '0;
                    if (!(in_grid(ci_reg, cj_reg) && rd_reg)) begin
                        // free cell: advance
                        if (!(last_j && last_i)) begin
                            if (last_j) begin
                                cj_reg <= miny; ci_reg <= ci_reg + 7'sd1;
                            end else cj_reg <= cj_reg + 7'sd1;
                        end
                    end
                end
                ST_EDGE: begin
                    if (sub_reg == 2'd0) ov_reg <= ov_now;
                    unique case (sub_reg)
                        2'd0: s1_reg <= cs;
                        2'd1: s2_reg <= cs;
                        2'd2: s3_reg <= cs;
                        default: ;
                    endcase
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd3) begin
                        if (edge_hit) begin
                            ans_reg <= 1'b1;
                            m_valid <= 1'b1;
                        end else if (step_reg == 3'd3) begin
                            step_reg <= '0;
                            if (!(last_j && last_i)) begin
                                if (last_j) begin
                                    cj_reg <= miny; ci_reg <= ci_reg + 7'sd1;
                                end else cj_reg <= cj_reg + 7'sd1;
                            end
                        end else step_reg <= step_reg + 3'd1;
                    end
                end
                ST_GATE: begin
                    step_reg <= step_reg + 3'd1;
                    unique case (step_reg)
                        3'd0: begin s1_reg <= cs; ov_reg <= ov_now; end
                        3'd1: s2_reg <= cs;
                        3'd2: s3_reg <= cs;
                        3'd3: ov_reg <= edge_hit;
                        3'd4: s1_reg <= cs;          // sn
                        3'd5: s2_reg <= cs;          // se
                        default: begin               // ss
                            ans_reg <= ov_reg &&
                                !((4'(s2_reg) * 4'(s1_reg) >= 0) &&
                                  (4'(cs) * 4'(s1_reg) < 0));
                            m_valid <= 1'b1;
                        end
                    endcase
                end
                ST_OUT: if (m_ready) m_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    assign m_answer      = ans_reg;
    assign m_out_of_grid = oog_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accepting while result pending");
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("result outside output state");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_answer))
        else $error("result dropped");
endmodule
`default_nettype wire

// ----- sim/tb_grid_segment_obstacle_check.sv -----
// Self-checking testbench for grid_segment_obstacle_check: random and directed
// commands, scoreboard against an inline occupancy/segment predictor.
// Depends on gsoc_pkg and the block's RTL only.
`default_nettype none
module tb_grid_segment_obstacle_check
    import gsoc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW = GRID_W_DEF;
    localparam int GH = GRID_H_DEF;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic answer;
        logic oog;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_GATE_LX;
    logic [5:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = MODE_CELL;
    logic signed [6:0] s_x_from = '0, s_y_from = '0, s_x_to = '0, s_y_to = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_answer, m_out_of_grid;

    grid_segment_obstacle_check u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_x_from(s_x_from), .s_y_from(s_y_from), .s_x_to(s_x_to), .s_y_to(s_y_to),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_answer(m_answer), .m_out_of_grid(m_out_of_grid)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor state
    bit occ_map [GW*GH];
    int gate_lx = 14, gate_ly = 15, gate_rx = 15, gate_ry = 14;
    verdict_t verdict_q[$];
    int errors = 0;
    int hold_left = 0;
    int burst_left = 0;

    function automatic int sg(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint cross3(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic bit spans_meet(longint a, longint b, longint c, longint d);
        longint lo1, hi1, lo2, hi2;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        lo2 = (c < d) ? c : d;
        hi2 = (c < d) ? d : c;
        return ((lo1 > lo2) ? lo1 : lo2) <= ((hi1 < hi2) ? hi1 : hi2);
    endfunction

    function automatic bit segs_touch(longint p1x, longint p1y, longint p2x, longint p2y,
                                      longint q1x, longint q1y, longint q2x, longint q2y);
        return spans_meet(p1x, p2x, q1x, q2x) && spans_meet(p1y, p2y, q1y, q2y)
            && sg(cross3(p1x, p1y, p2x, p2y, q1x, q1y))
               * sg(cross3(p1x, p1y, p2x, p2y, q2x, q2y)) <= 0
            && sg(cross3(q1x, q1y, q2x, q2y, p1x, p1y))
               * sg(cross3(q1x, q1y, q2x, q2y, p2x, p2y)) <= 0;
    endfunction

    // gate vector used as a point, exactly as the block defines it
    function automatic bit gate_violated(int x0, int y0, int x1, int y1);
        int sn, se, ss;
        if (!segs_touch(x0, y0, x1, y1, gate_lx, gate_ly, gate_rx, gate_ry))
            return 1'b0;
        sn = sg(cross3(gate_lx, gate_ly, gate_rx - gate_lx, gate_ry - gate_ly,
                       gate_rx, gate_ry));
        se = sg(cross3(gate_lx, gate_ly, x1, y1, gate_rx, gate_ry));
        ss = sg(cross3(gate_lx, gate_ly, x0, y0, gate_rx, gate_ry));
        return !(se * sn >= 0 && ss * sn < 0);
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < GW && y < GH;
    endfunction

    function automatic bit move_blocked(int x0, int y0, int x1, int y1);
        longint ax, ay, bx, by, l, r, t, b;
        ax = x0 * 10 + 5; ay = y0 * 10 + 5;
        bx = x1 * 10 + 5; by = y1 * 10 + 5;
        for (int i = (x0 < x1 ? x0 : x1); i <= (x0 < x1 ? x1 : x0); i++) begin
            for (int j = (y0 < y1 ? y0 : y1); j <= (y0 < y1 ? y1 : y0); j++) begin
                if (!on_grid(i, j) || !occ_map[j*GW+i]) continue;
                l = i * 10; r = l + 10; t = j * 10; b = t + 10;
                if (segs_touch(ax, ay, bx, by, l, t, r, t) ||
                    segs_touch(ax, ay, bx, by, r, t, r, b) ||
                    segs_touch(ax, ay, bx, by, r, b, l, b) ||
                    segs_touch(ax, ay, bx, by, l, b, l, t))
                    return 1'b1;
            end
        end
        return gate_violated(x0, y0, x1, y1);
    endfunction

    function automatic verdict_t run_command(logic [1:0] mode, int x0, int y0,
                                             int x1, int y1);
        verdict_t v;
        bit ok0;
        ok0 = on_grid(x0, y0);
        v = '0;
        case (mode) inside
            MODE_SET_BLOCKED, MODE_SET_FREE: begin
                if (ok0) occ_map[y0*GW+x0] = (mode == MODE_SET_BLOCKED);
                v.oog = !ok0;
            end
            MODE_PATH: begin
                v.oog = !(ok0 && on_grid(x1, y1));
                v.answer = move_blocked(x0, y0, x1, y1);
            end
            default: begin
                v.oog = !ok0;
                v.answer = ok0 && !occ_map[y0*GW+x0];
            end
        endcase
        return v;
    endfunction

    // send one item; valid stays high across a burst
    task automatic send_cmd(logic [1:0] mode, logic signed [6:0] x0, logic signed [6:0] y0,
                            logic signed [6:0] x1, logic signed [6:0] y1);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_mode <= mode;
        s_x_from <= x0; s_y_from <= y0; s_x_to <= x1; s_y_to <= y1;
        do @(posedge aclk); while (!s_ready);
        verdict_q.push_back(run_command(mode, int'(x0), int'(y0), int'(x1), int'(y1)));
    endtask

    task automatic drain();
        if (burst_left != 0 || s_valid) begin
            s_valid <= 1'b0;
            burst_left = 0;
            @(posedge aclk);
        end
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic set_gate(logic [5:0] lx, logic [5:0] ly, logic [5:0] rx, logic [5:0] ry);
        drain();
        cfg_write(CFG_GATE_LX, lx);
        cfg_write(CFG_GATE_LY, ly);
        cfg_write(CFG_GATE_RX, rx);
        cfg_write(CFG_GATE_RY, ry);
        cfg_we <= 1'b0;
        gate_lx = lx; gate_ly = ly; gate_rx = rx; gate_ry = ry;
        @(posedge aclk);
    endtask

    function automatic logic signed [6:0] rand_coord(int dim);
        if ($urandom_range(0, 9) == 0) return 7'($urandom);
        return 7'($urandom_range(0, dim - 1));
    endfunction

    task automatic rand_cmd();
        logic signed [6:0] x0, y0, x1, y1;
        int pick;
        pick = $urandom_range(0, 99);
        x0 = rand_coord(GW); y0 = rand_coord(GH);
        x1 = 7'($urandom); y1 = 7'($urandom);
        if (pick < 30) send_cmd(MODE_SET_BLOCKED, x0, y0, x1, y1);
        else if (pick < 45) send_cmd(MODE_SET_FREE, x0, y0, x1, y1);
        else if (pick < 80) begin
            // keep most boxes small so scans stay short
            if ($urandom_range(0, 9) != 0) begin
                x1 = x0 + 7'($urandom_range(0, 6)) - 7'sd3;
                y1 = y0 + 7'($urandom_range(0, 6)) - 7'sd3;
            end
            send_cmd(MODE_PATH, x0, y0, x1, y1);
        end else send_cmd(MODE_CELL, x0, y0, x1, y1);
    endtask

    task automatic test_directed();
        send_cmd(MODE_CELL, 7'sd0, 7'sd0, 7'sd0, 7'sd0);
        send_cmd(MODE_SET_BLOCKED, 7'sd0, 7'sd0, -7'sd1, 7'sd63);
        send_cmd(MODE_SET_BLOCKED, 7'sd15, 7'sd15, 7'sd0, 7'sd0);
        send_cmd(MODE_SET_BLOCKED, 7'sd5, 7'sd5, 7'sd0, 7'sd0);
        send_cmd(MODE_CELL, 7'sd0, 7'sd0, 7'sd0, 7'sd0);
        send_cmd(MODE_CELL, 7'sd15, 7'sd15, 7'sd0, 7'sd0);
        // ignored writes outside the grid
        send_cmd(MODE_SET_BLOCKED, -7'sd64, 7'sd63, 7'sd0, 7'sd0);
        send_cmd(MODE_SET_FREE, 7'sd16, 7'sd3, 7'sd0, 7'sd0);
        send_cmd(MODE_CELL, 7'sd3, 7'sd16, 7'sd0, 7'sd0);
        send_cmd(MODE_CELL, -7'sd1, 7'sd0, 7'sd0, 7'sd0);
        send_cmd(MODE_PATH, 7'sd4, 7'sd4, 7'sd6, 7'sd6);
        send_cmd(MODE_PATH, 7'sd4, 7'sd5, 7'sd9, 7'sd5);
        send_cmd(MODE_PATH, 7'sd4, 7'sd4, 7'sd6, 7'sd4);
        send_cmd(MODE_PATH, 7'sd5, 7'sd5, 7'sd5, 7'sd5);
        send_cmd(MODE_PATH, -7'sd64, -7'sd64, 7'sd63, 7'sd63);
        send_cmd(MODE_PATH, 7'sd0, 7'sd0, 7'sd15, 7'sd15);
        // across, touching and beside the default gate
        send_cmd(MODE_PATH, 7'sd14, 7'sd14, 7'sd15, 7'sd15);
        send_cmd(MODE_PATH, 7'sd13, 7'sd13, 7'sd12, 7'sd12);
        send_cmd(MODE_PATH, 7'sd10, 7'sd15, 7'sd20, 7'sd15);
        send_cmd(MODE_SET_FREE, 7'sd5, 7'sd5, 7'sd0, 7'sd0);
        send_cmd(MODE_PATH, 7'sd4, 7'sd4, 7'sd6, 7'sd6);
        send_cmd(MODE_SET_FREE, 7'sd0, 7'sd0, 7'sd0, 7'sd0);
    endtask

    task automatic test_gate_settings();
        set_gate(6'd0, 6'd0, 6'd63, 6'd63);
        repeat (150) rand_cmd();
        set_gate(6'd63, 6'd0, 6'd0, 6'd63);
        repeat (150) rand_cmd();
        set_gate(6'd0, 6'd8, 6'd15, 6'd8);
        repeat (150) rand_cmd();
        set_gate(6'd8, 6'd0, 6'd8, 6'd15);
        repeat (150) rand_cmd();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            set_gate(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
            repeat (300) rand_cmd();
        end
    endtask

    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (30) rand_cmd();
    endtask

    // result side: stall pattern, long hold when asked, scoreboard
    initial begin
        int cyc, stall_pct;
        verdict_t want;
        cyc = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result at %0t", $realtime);
                end else begin
                    want = verdict_q.pop_front();
                    if (want.answer !== m_answer || want.oog !== m_out_of_grid) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at %0t: want answer=%b oog=%b got %b %b",
                                     $realtime, want.answer, want.oog,
                                     m_answer, m_out_of_grid);
                    end
                end
            end
            if (cyc % 200 == 0) stall_pct = 30 * $urandom_range(0, 2);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // stop if nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("tb_grid_segment_obstacle_check NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_gate_settings();
        test_random();
        test_backpressure();
        set_gate(6'd14, 6'd15, 6'd15, 6'd14);
        repeat (100) rand_cmd();
        drain();
        if (errors == 0) $display("tb_grid_segment_obstacle_check OK");
        else $display("tb_grid_segment_obstacle_check NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ----- grid_segment_obstacle_check.f -----
rtl/gsoc_pkg.sv
rtl/grid_segment_obstacle_check.sv
sim/tb_grid_segment_obstacle_check.sv
